// ----- design/assert_macros.svh -----
// Assertion helpers for the design files, used by first_fit_extent_allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define FFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/ffa_pkg.sv -----
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared constants, status codes and sequencer states of the extent allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

   localparam int POOL_BYTES     = 16777216;
   localparam int EXTENT_ENTRIES = 64;
   localparam int BLOCK_ENTRIES  = 64;

   localparam int ADDR_W = 24;
   localparam int SIZE_W = 25;
   localparam int SLOT_W = ADDR_W + SIZE_W;

   localparam int EXT_IW = $clog2(EXTENT_ENTRIES);
   localparam int BLK_IW = $clog2(BLOCK_ENTRIES);
   localparam int CNT_W  = $clog2(EXTENT_ENTRIES + 1);
   localparam int MAX_ENTRIES =
      (EXTENT_ENTRIES > BLOCK_ENTRIES) ? EXTENT_ENTRIES : BLOCK_ENTRIES;
   localparam int SCAN_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [0:0] REQ_ALLOC = 1'b0;
   localparam logic [0:0] REQ_FREE  = 1'b1;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_NO_SPACE   = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND  = 2'd2;
   localparam logic [1:0] STAT_TABLE_FULL = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIT,
      S_SLOT,
      S_LOOK,
      S_ALLOC_WR,
      S_FREE_WR
   } state_type;

endpackage

// ----- design/ffa_ram.sv -----
// ---------------------------------------------------------------------------
// ffa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/first_fit_extent_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit allocator over one byte pool, with a free-extent table and an
// allocated-block table held in RAM and walked by a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): req_type 0 allocates req_size bytes, 1 frees the
//   block starting at req_addr. A beat is taken when req_valid is high and
//   req_stall is low. req_stall stays high from acceptance until the answer
//   beat has left the rsp_* register.
//   Response channel (rsp_*): one beat per request, carrying rsp_grant_addr
//   (zero unless an allocate succeeds) and rsp_status.
//   An allocate walks the extent RAM one entry per cycle up to the first
//   extent that fits, then the block valid bits one slot per cycle up to a
//   free slot; with no fitting extent it answers STAT_NO_SPACE after the
//   extent walk, and a size above the free total is answered without a walk.
//   Free walks the block RAM read port one entry per cycle up to the lowest
//   valid block with a matching start, and answers STAT_NOT_FOUND if none.
//   A full block table answers an allocate with STAT_TABLE_FULL.
//   Reset: synchronous, clears the sequencer, the block valid bits and the
//   extent count (one extent covering the whole pool). No clearing pass.
//   A stalled answer holds in the output register; no new request is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_extent_allocator import ffa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [SIZE_W-1:0] req_size,
   input  logic [ADDR_W-1:0] req_addr,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_grant_addr,
   output logic [1:0]        rsp_status
);

   // sequencer and control
   state_type            state_ff, state_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;      // next entry to read
   logic [SCAN_W-1:0]    chk_ff, chk_in;        // entry whose data is on the RAM output
   logic                 pend_ff, pend_in;      // RAM output holds a fresh entry
   logic [CNT_W-1:0]     ext_count_ff, ext_count_in;
   logic                 ext0_fresh_ff, ext0_fresh_in; // entry 0 still at reset value
   logic [BLOCK_ENTRIES-1:0] valid_ff, valid_in;
   logic [SIZE_W-1:0]    free_total_ff, free_total_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    cap_start_ff, cap_start_in;
   logic [SIZE_W-1:0]    cap_len_ff, cap_len_in;
   logic [EXT_IW-1:0]    ei_ff, ei_in;
   logic [BLK_IW-1:0]    bi_ff, bi_in;
   logic [ADDR_W-1:0]    grant_ff, grant_in;
   logic [1:0]           status_ff, status_in;

   // RAM ports
   logic                 ext_we, blk_we;
   logic [EXT_IW-1:0]    ext_waddr;
   logic [BLK_IW-1:0]    blk_waddr;
   logic [SLOT_W-1:0]    ext_wdata, blk_wdata, ext_rdata, blk_rdata;

   // decoded read data
   logic [ADDR_W-1:0]    ext_start, blk_start;
   logic [SIZE_W-1:0]    ext_len, blk_len;
   logic                 more;

   ffa_ram #(.WIDTH(SLOT_W), .DEPTH(EXTENT_ENTRIES)) u_ext_ram (
      .clock   (clock),
      .wr_en   (ext_we),
      .wr_addr (ext_waddr),
      .wr_data (ext_wdata),
      .rd_addr (scan_ff[EXT_IW-1:0]),
      .rd_data (ext_rdata)
   );

   ffa_ram #(.WIDTH(SLOT_W), .DEPTH(BLOCK_ENTRIES)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_waddr),
      .wr_data (blk_wdata),
      .rd_addr (scan_ff[BLK_IW-1:0]),
      .rd_data (blk_rdata)
   );

   // Entry 0 reads as the whole pool until first written.
   always_comb begin
      if (ext0_fresh_ff && (chk_ff[EXT_IW-1:0] == '0)) begin
         ext_start = '0;
         ext_len   = SIZE_W'(POOL_BYTES);
      end else begin
         ext_start = ext_rdata[ADDR_W-1:0];
         ext_len   = ext_rdata[SLOT_W-1:ADDR_W];
      end
      blk_start = blk_rdata[ADDR_W-1:0];
      blk_len   = blk_rdata[SLOT_W-1:ADDR_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= '0;
         chk_ff        <= '0;
         pend_ff       <= 1'b0;
         ext_count_ff  <= CNT_W'(1);
         ext0_fresh_ff <= 1'b1;
         valid_ff      <= '0;
         free_total_ff <= SIZE_W'(POOL_BYTES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         chk_ff        <= chk_in;
         pend_ff       <= pend_in;
         ext_count_ff  <= ext_count_in;
         ext0_fresh_ff <= ext0_fresh_in;
         valid_ff      <= valid_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      cap_start_ff <= cap_start_in;
      cap_len_ff   <= cap_len_in;
      ei_ff        <= ei_in;
      bi_ff        <= bi_in;
      grant_ff     <= grant_in;
      status_ff    <= status_in;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      pend_in       = 1'b0;
      ext_count_in  = ext_count_ff;
      ext0_fresh_in = ext0_fresh_ff;
      valid_in      = valid_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      size_in       = size_ff;
      addr_in       = addr_ff;
      cap_start_in  = cap_start_ff;
      cap_len_in    = cap_len_ff;
      ei_in         = ei_ff;
      bi_in         = bi_ff;
      grant_in      = grant_ff;
      status_in     = status_ff;
      ext_we        = 1'b0;
      blk_we        = 1'b0;
      ext_waddr     = ei_ff;
      blk_waddr     = bi_ff;
      ext_wdata     = {cap_len_ff - size_ff, cap_start_ff + size_ff[ADDR_W-1:0]};
      blk_wdata     = {size_ff, cap_start_ff};
      more          = 1'b0;
      req_stall     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = rsp_valid_ff;
            scan_in   = '0;
            if (req_valid && !rsp_valid_ff) begin
               size_in  = req_size;
               addr_in  = req_addr;
               grant_in = '0;
               if (req_type == REQ_FREE) begin
                  state_in = S_LOOK;
               end else if (req_size > free_total_ff) begin
                  status_in    = STAT_NO_SPACE;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_FIT;
               end
            end
         end

         // walk extents 0..count-1, first with length >= size wins
         S_FIT: begin
            more = scan_ff < SCAN_W'(ext_count_ff);
            if (pend_ff && (size_ff <= ext_len)) begin
               cap_start_in = ext_start;
               cap_len_in   = ext_len;
               ei_in        = chk_ff[EXT_IW-1:0];
               scan_in      = '0;
               state_in     = S_SLOT;
            end else if (more) begin
               pend_in = 1'b1;
               chk_in  = scan_ff;
               scan_in = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               status_in    = STAT_NO_SPACE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // first free block slot, one valid bit per cycle
         S_SLOT: begin
            if (!valid_ff[scan_ff[BLK_IW-1:0]]) begin
               bi_in    = scan_ff[BLK_IW-1:0];
               state_in = S_ALLOC_WR;
            end else if (scan_ff[BLK_IW-1:0] == BLK_IW'(BLOCK_ENTRIES - 1)) begin
               status_in    = STAT_TABLE_FULL;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_ALLOC_WR: begin
            ext_we         = 1'b1;
            blk_we         = 1'b1;
            valid_in[bi_ff] = 1'b1;
            if (ei_ff == '0) begin
               ext0_fresh_in = 1'b0;
            end
            free_total_in = free_total_ff - size_ff;
            grant_in      = cap_start_ff;
            status_in     = STAT_OK;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         // lowest valid block whose start matches
         S_LOOK: begin
            more = scan_ff < SCAN_W'(BLOCK_ENTRIES);
            if (pend_ff && valid_ff[chk_ff[BLK_IW-1:0]] && (blk_start == addr_ff)) begin
               cap_start_in = blk_start;
               cap_len_in   = blk_len;
               bi_in        = chk_ff[BLK_IW-1:0];
               if (ext_count_ff >= CNT_W'(EXTENT_ENTRIES)) begin
                  status_in    = STAT_TABLE_FULL;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_FREE_WR;
               end
            end else if (more) begin
               pend_in = 1'b1;
               chk_in  = scan_ff;
               scan_in = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               status_in    = STAT_NOT_FOUND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_FREE_WR: begin
            ext_we          = 1'b1;
            ext_waddr       = ext_count_ff[EXT_IW-1:0];
            ext_wdata       = {cap_len_ff, cap_start_ff};
            valid_in[bi_ff] = 1'b0;
            ext_count_in    = ext_count_ff + 1'b1;
            free_total_in   = free_total_ff + cap_len_ff;
            status_in       = STAT_OK;
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grant_addr = grant_ff;
   assign rsp_status     = status_ff;

   // checks
   `FFA_ASSERT(a_busy_stalls, (state_ff != S_IDLE) |-> req_stall, "request taken while busy")
   `FFA_ASSERT(a_accept_busy, (req_valid && !req_stall && (req_type == REQ_FREE)) |=> (state_ff == S_LOOK), "free did not start lookup")
   `FFA_ASSERT(a_free_bound, free_total_ff <= SIZE_W'(POOL_BYTES), "free total above pool size")
   `FFA_ASSERT(a_count_range, (ext_count_ff != '0) && (ext_count_ff <= CNT_W'(EXTENT_ENTRIES)), "extent count out of range")

endmodule
